// ===== rtl/core/rcam_pkg.sv =====
// rounded corner alpha mask: shared widths, register indexes and stage types
// no dependencies; imported by every module of the block
package rcam_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int ALPHA_W    = 8;

  localparam int DIM_W    = COORD_BITS + 1;
  localparam int SGN_W    = DIM_W + 1;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int S_W      = SQ_W + 1;
  localparam int RSQ_W    = 2 * COORD_BITS;
  localparam int R1SQ_W   = 2 * (COORD_BITS + 1);
  localparam int ROOT_W   = COORD_BITS + FRAC_BITS;
  localparam int REM_W    = ROOT_W + 1;
  localparam int STEP_W   = REM_W + 2;
  localparam int N_CORNER = 4;

  localparam int IN_RAW_W   = 2 * COORD_BITS + ALPHA_W;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ALPHA_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CORNER_RADIUS = 2'd2;

  localparam logic [DIM_W-1:0]      RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [DIM_W-1:0]      RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [COORD_BITS-1:0] RST_CORNER_RADIUS = 12'd100;

  // corner order: later corners win
  localparam int CORNER_TL = 0;
  localparam int CORNER_TR = 1;
  localparam int CORNER_BL = 2;
  localparam int CORNER_BR = 3;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [N_CORNER-1:0] zone;
    logic [DIFF_W-1:0]   ax_l;
    logic [DIFF_W-1:0]   ax_r;
    logic [DIFF_W-1:0]   ay_t;
    logic [DIFF_W-1:0]   ay_b;
  } geo_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [N_CORNER-1:0] zone;
    logic [SQ_W-1:0]     sq_xl;
    logic [SQ_W-1:0]     sq_xr;
    logic [SQ_W-1:0]     sq_yt;
    logic [SQ_W-1:0]     sq_yb;
  } sqr_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [N_CORNER-1:0] zone;
    logic [S_W-1:0]      s_tl;
    logic [S_W-1:0]      s_tr;
    logic [S_W-1:0]      s_bl;
    logic [S_W-1:0]      s_br;
  } sum_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               hit;
    logic               clear;
    logic [S_W-1:0]     s_sel;
  } sel_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               hit;
    logic               clear;
    logic [ROOT_W-1:0]  root;
    logic [REM_W-1:0]   rem;
  } sq_t;

endpackage

// ===== rtl/core/rounded_corner_alpha_mask.sv =====
// rounded corner alpha mask top level: config registers, stream ports, pipeline
// uses rcam_pkg, rcam_geom, rcam_sqrt_step, rcam_out
//
// Each pixel enters on the in_ stream with its row, column and alpha and leaves
// on the out_ stream with its new alpha, one result per pixel, in order.
// Pixels inside one of the four corner circles pass unchanged, pixels past the
// circle edge by a whole pixel or more get alpha 0, and pixels on the edge get
// an antialiased alpha from a 16 fraction bit square root.
// The cfg_ port writes image_width (0), image_height (1) and corner_radius (2);
// write only while no pixel is in flight.
// Throughput: one pixel per cycle while out_tready stays high.
// Pipeline: five geometry stages, one square root digit stage per fraction
// bit, and the output register.
// Reset clears all valid bits and loads 640 x 480 with radius 100.
// When the receiver stalls, a skid register takes the one result that is
// already on its way; while it is full, in_tready drops and the whole
// pipeline holds. in_tready comes from a register, not from out_tready.
module rounded_corner_alpha_mask
  import rcam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pixel_row, pixel_col, alpha_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // alpha_out
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DIM_W-1:0]      width_r, height_r;
  logic [COORD_BITS-1:0] radius_r;
  logic [RSQ_W-1:0]      rsq_r;
  logic [R1SQ_W-1:0]     r1sq_r;
  logic [COORD_BITS:0]   r1;
  logic                  en;
  logic                  sq_v [FRAC_BITS+1];
  sq_t                   sq_d [FRAC_BITS+1];
  logic [ALPHA_W-1:0]    alpha_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      radius_r <= RST_CORNER_RADIUS;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:   width_r  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  height_r <= cfg_wdata[DIM_W-1:0];
        REG_CORNER_RADIUS: radius_r <= cfg_wdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // radius squares, registered, so they follow the radius register in the next cycle
  assign r1 = {1'b0, radius_r} + (COORD_BITS+1)'(1);

  always_ff @(posedge clk) begin
    rsq_r  <= RSQ_W'(radius_r) * RSQ_W'(radius_r);
    r1sq_r <= R1SQ_W'(r1) * R1SQ_W'(r1);
  end

  assign in_tready = en;

  rcam_geom u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_tvalid && in_tready),
    .pixel_row     (in_tdata[COORD_BITS-1:0]),
    .pixel_col     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .alpha_in      (in_tdata[IN_RAW_W-1:2*COORD_BITS]),
    .image_width   (width_r),
    .image_height  (height_r),
    .corner_radius (radius_r),
    .rsq           (rsq_r),
    .r1sq          (r1sq_r),
    .out_valid     (sq_v[0]),
    .out_data      (sq_d[0])
  );

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_sqrt
    rcam_sqrt_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[g]),
      .in_data   (sq_d[g]),
      .out_valid (sq_v[g+1]),
      .out_data  (sq_d[g+1])
    );
  end

  rcam_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sq_v[FRAC_BITS]),
    .in_data    (sq_d[FRAC_BITS]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .alpha_out  (alpha_out),
    .en         (en)
  );

  assign out_tdata = OUT_DATA_W'(alpha_out);

`ifndef SYNTHESIS
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("pipeline held with no result waiting");

  a_seed_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[0] && sq_d[0].hit && !sq_d[0].clear |->
      sq_d[0].rem <= REM_W'({radius_r, 1'b0}))
    else $error("square root seed remainder out of range");

  a_root_int_part: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[FRAC_BITS] && sq_d[FRAC_BITS].hit && !sq_d[FRAC_BITS].clear |->
      sq_d[FRAC_BITS].root[ROOT_W-1:FRAC_BITS] == radius_r)
    else $error("edge root integer part differs from radius");
`endif

endmodule

// ===== rtl/core/rcam_geom.sv =====
// corner geometry pipeline: zone tests, squares, distance sums, corner select
// and square root seed; uses rcam_pkg
module rcam_geom
  import rcam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] pixel_row,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic [ALPHA_W-1:0]    alpha_in,
  input  logic [DIM_W-1:0]      image_width,
  input  logic [DIM_W-1:0]      image_height,
  input  logic [COORD_BITS-1:0] corner_radius,
  input  logic [RSQ_W-1:0]      rsq,
  input  logic [R1SQ_W-1:0]     r1sq,
  output logic                  out_valid,
  output sq_t                   out_data
);

  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  geo_t a_r, a_nxt;
  sqr_t b_r, b_nxt;
  sum_t c_r, c_nxt;
  sel_t d_r, d_nxt;
  sq_t  e_r, e_nxt;

  // stage a: zone flags and absolute offsets from the corner centers
  always_comb begin
    logic signed [SGN_W-1:0] row_s, col_s, rad_s, right_s, bottom_s;
    logic signed [SGN_W-1:0] t_xl, t_xr, t_yt, t_yb;
    logic row_top, row_bot, col_lft, col_rgt;
    row_s    = $signed({{(SGN_W-COORD_BITS){1'b0}}, pixel_row});
    col_s    = $signed({{(SGN_W-COORD_BITS){1'b0}}, pixel_col});
    rad_s    = $signed({{(SGN_W-COORD_BITS){1'b0}}, corner_radius});
    right_s  = $signed({1'b0, image_width}) - rad_s;
    bottom_s = $signed({1'b0, image_height}) - rad_s;
    row_top  = row_s < rad_s;
    row_bot  = row_s > bottom_s;
    col_lft  = col_s < rad_s;
    col_rgt  = col_s > right_s;
    t_xl     = rad_s - col_s;
    t_xr     = col_s - right_s;
    t_yt     = rad_s - row_s;
    t_yb     = row_s - bottom_s;
    a_nxt.alpha           = alpha_in;
    a_nxt.zone[CORNER_TL] = row_top && col_lft;
    a_nxt.zone[CORNER_TR] = row_top && col_rgt;
    a_nxt.zone[CORNER_BL] = row_bot && col_lft;
    a_nxt.zone[CORNER_BR] = row_bot && col_rgt;
    a_nxt.ax_l            = t_xl[DIFF_W-1:0];
    a_nxt.ax_r            = t_xr[DIFF_W-1:0];
    a_nxt.ay_t            = t_yt[DIFF_W-1:0];
    a_nxt.ay_b            = t_yb[DIFF_W-1:0];
  end

  // stage b: squares
  always_comb begin
    b_nxt.alpha = a_r.alpha;
    b_nxt.zone  = a_r.zone;
    b_nxt.sq_xl = SQ_W'(a_r.ax_l) * SQ_W'(a_r.ax_l);
    b_nxt.sq_xr = SQ_W'(a_r.ax_r) * SQ_W'(a_r.ax_r);
    b_nxt.sq_yt = SQ_W'(a_r.ay_t) * SQ_W'(a_r.ay_t);
    b_nxt.sq_yb = SQ_W'(a_r.ay_b) * SQ_W'(a_r.ay_b);
  end

  // stage c: squared distances per corner
  always_comb begin
    c_nxt.alpha = b_r.alpha;
    c_nxt.zone  = b_r.zone;
    c_nxt.s_tl  = {1'b0, b_r.sq_yt} + {1'b0, b_r.sq_xl};
    c_nxt.s_tr  = {1'b0, b_r.sq_yt} + {1'b0, b_r.sq_xr};
    c_nxt.s_bl  = {1'b0, b_r.sq_yb} + {1'b0, b_r.sq_xl};
    c_nxt.s_br  = {1'b0, b_r.sq_yb} + {1'b0, b_r.sq_xr};
  end

  // stage d: last corner beyond the radius wins
  always_comb begin
    logic [S_W-1:0]      rsq_x, r1sq_x;
    logic [S_W-1:0]      s_k [N_CORNER];
    logic [N_CORNER-1:0] hit;
    logic [S_W-1:0]      sel;
    rsq_x  = {{(S_W-RSQ_W){1'b0}}, rsq};
    r1sq_x = {{(S_W-R1SQ_W){1'b0}}, r1sq};
    s_k[CORNER_TL] = c_r.s_tl;
    s_k[CORNER_TR] = c_r.s_tr;
    s_k[CORNER_BL] = c_r.s_bl;
    s_k[CORNER_BR] = c_r.s_br;
    sel = '0;
    for (int k = 0; k < N_CORNER; k++) begin
      hit[k] = c_r.zone[k] && (s_k[k] > rsq_x);
      if (hit[k]) begin
        sel = s_k[k];
      end
    end
    d_nxt.alpha = c_r.alpha;
    d_nxt.hit   = |hit;
    d_nxt.clear = sel >= r1sq_x;
    d_nxt.s_sel = sel;
  end

  // stage e: integer part of the root is the radius, remainder is s - r*r
  always_comb begin
    logic [S_W-1:0] diff;
    diff        = d_r.s_sel - {{(S_W-RSQ_W){1'b0}}, rsq};
    e_nxt.alpha = d_r.alpha;
    e_nxt.hit   = d_r.hit;
    e_nxt.clear = d_r.clear;
    e_nxt.root  = {{(ROOT_W-COORD_BITS){1'b0}}, corner_radius};
    e_nxt.rem   = diff[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
      e_r <= e_nxt;
    end
  end

  assign out_valid = v_e_r;
  assign out_data  = e_r;

endmodule

// ===== rtl/core/rcam_sqrt_step.sv =====
// one registered digit step of the fractional square root
// uses rcam_pkg
module rcam_sqrt_step
  import rcam_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  sq_t  in_data,
  output logic out_valid,
  output sq_t  out_data
);

  logic valid_r;
  sq_t  data_r, data_nxt;

  always_comb begin
    logic [STEP_W-1:0] rem_sh, trial, diff;
    rem_sh   = {in_data.rem, 2'b00};
    trial    = {1'b0, in_data.root, 2'b01};
    diff     = rem_sh - trial;
    data_nxt = in_data;
    if (rem_sh >= trial) begin
      data_nxt.rem  = diff[REM_W-1:0];
      data_nxt.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_nxt.rem  = rem_sh[REM_W-1:0];
      data_nxt.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/core/rcam_out.sv =====
// final alpha select, output register and skid register
// uses rcam_pkg
module rcam_out
  import rcam_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  sq_t                in_data,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [ALPHA_W-1:0] alpha_out,
  output logic               en
);

  logic               out_valid_r, skid_valid_r;
  logic [ALPHA_W-1:0] out_alpha_r, skid_alpha_r;
  logic [ALPHA_W-1:0] alpha_c;
  logic               push;

  // antialiased alpha: 255 * (1 - e) truncated, e = fraction of the root
  always_comb begin
    logic [FRAC_BITS:0]           x;
    logic [FRAC_BITS+ALPHA_W:0]   prod;
    x    = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, in_data.root[FRAC_BITS-1:0]};
    prod = {x, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, x};
    if (!in_data.hit) begin
      alpha_c = in_data.alpha;
    end else if (in_data.clear) begin
      alpha_c = '0;
    end else begin
      alpha_c = prod[FRAC_BITS+ALPHA_W-1:FRAC_BITS];
    end
  end

  assign en   = !skid_valid_r;
  assign push = en && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_alpha_r <= skid_alpha_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_tready) begin
        skid_alpha_r <= alpha_c;
      end else begin
        out_alpha_r <= alpha_c;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign alpha_out  = out_alpha_r;

endmodule
